// ===== rtl/core/lgs_pkg.sv =====
`default_nettype none

package lgs_pkg;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);
  // sweep counter runs 0 .. GRID_ROWS + 2
  localparam int SW_W  = $clog2(GRID_ROWS + 3);

  localparam int OP_W   = 2;
  localparam int FIELD_W = 6;
  // wide enough to compare a field against a grid size up to 256
  localparam int CMP_W  = 9;

  localparam logic [OP_W-1:0] OP_TOGGLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  typedef struct packed {
    logic            capture;
    logic            clear;
    logic            issue;
    logic            look;
    logic            toggle;
    logic            sweep;
    logic [SW_W-1:0] cnt;
    logic            load_out;
  } lgs_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/life_grid_generation_step.sv =====
// channel  ports                                      transaction when
// -------  -----------------------------------------  ---------------------
// in       in_valid in_ready in_op in_row in_col      in_valid & in_ready
// out      out_valid out_ready out_cell_alive         out_valid & out_ready
//
// advance runs as a row sweep: one grid row read and another written per
// cycle through the one-read one-write row memory, plus the window fill and final row
// reset is synchronous; per-row valid bits make the grid read as all dead
// a finished result sits in the output register while the next transaction
// is taken; a stalled output holds the following result in its last state
`default_nettype none

module life_grid_generation_step (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [lgs_pkg::OP_W-1:0]     in_op,
  input  wire logic [lgs_pkg::FIELD_W-1:0]  in_row,
  input  wire logic [lgs_pkg::FIELD_W-1:0]  in_col,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_cell_alive
);

  lgs_pkg::lgs_cmd_t cmd;

  lgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lgs_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_row         (in_row),
    .in_col         (in_col),
    .cmd            (cmd),
    .out_cell_alive (out_cell_alive)
  );

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("input taken while previous transaction in flight");

  a_clear_on_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (in_valid && in_ready && (in_op == lgs_pkg::OP_CLEAR))
  ) else $error("grid clear outside an accepted clear transaction");

  a_out_from_load: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load_out)
  ) else $error("result shown without a load");

  a_no_load_while_held: assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready)
  ) else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

// ===== rtl/core/lgs_ctrl.sv =====
`default_nettype none

module lgs_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [lgs_pkg::OP_W-1:0]  in_op,
  output logic                           in_ready,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output lgs_pkg::lgs_cmd_t              cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  localparam logic [lgs_pkg::SW_W-1:0] CNT_LAST =
    lgs_pkg::SW_W'(lgs_pkg::GRID_ROWS + 2);

  logic [2:0]                state_r, state_nxt;
  logic [lgs_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [lgs_pkg::SW_W-1:0]  cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      in_fire;
  logic                      out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;

    cmd          = '0;
    cmd.cnt      = cnt_r;
    cmd.toggle   = (op_r == lgs_pkg::OP_TOGGLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          op_nxt      = in_op;
          cnt_nxt     = '0;
          unique case (in_op)
            lgs_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
              state_nxt = S_RESULT;
            end
            lgs_pkg::OP_ADVANCE: state_nxt = S_SWEEP;
            lgs_pkg::OP_TOGGLE,
            lgs_pkg::OP_READ:    state_nxt = S_ISSUE;
            default:             state_nxt = S_ISSUE;
          endcase
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_RESULT;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_ISSUE;
        end else begin
          cnt_nxt = cnt_r + lgs_pkg::SW_W'(1);
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= lgs_pkg::OP_TOGGLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lgs_datapath.sv =====
`default_nettype none

module lgs_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [lgs_pkg::FIELD_W-1:0]  in_row,
  input  wire logic [lgs_pkg::FIELD_W-1:0]  in_col,
  input  wire lgs_pkg::lgs_cmd_t            cmd,
  output logic                              out_cell_alive
);

  localparam int ROWS = lgs_pkg::GRID_ROWS;
  localparam int COLS = lgs_pkg::GRID_COLS;
  localparam int RW   = lgs_pkg::ROW_W;
  localparam int CW   = lgs_pkg::COL_W;
  localparam int SW   = lgs_pkg::SW_W;

  localparam logic [SW-1:0] CNT_UP   = SW'(1);
  localparam logic [SW-1:0] CNT_MID  = SW'(2);
  localparam logic [SW-1:0] CNT_ROWS = SW'(ROWS);
  localparam logic [SW-1:0] CNT_LAST = SW'(ROWS + 2);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld_r;

  logic [lgs_pkg::FIELD_W-1:0] row_r;
  logic [lgs_pkg::FIELD_W-1:0] col_r;
  logic [COLS-1:0] rd_data_r;
  logic            rd_vld_r;
  logic [COLS-1:0] up_r;
  logic [COLS-1:0] mid_r;
  logic [COLS-1:0] row0_r;
  logic            res_r;
  logic            out_cell_r;

  logic            addr_ok;
  logic [RW-1:0]   row_idx;
  logic [CW-1:0]   col_idx;
  logic [COLS-1:0] rd_row;
  logic [COLS-1:0] down_row;
  logic [COLS-1:0] next_row;
  logic [COLS-1:0] flip_mask;
  logic            rd_en;
  logic [RW-1:0]   rd_addr;
  logic            wr_en;
  logic [RW-1:0]   wr_addr;
  logic [COLS-1:0] wr_data;
  logic            sweep_body;

  assign addr_ok = (lgs_pkg::CMP_W'(row_r) < lgs_pkg::CMP_W'(ROWS)) &&
                   (lgs_pkg::CMP_W'(col_r) < lgs_pkg::CMP_W'(COLS));
  assign row_idx = addr_ok ? RW'(row_r) : '0;
  assign col_idx = addr_ok ? CW'(col_r) : '0;

  assign rd_row     = rd_vld_r ? rd_data_r : '0;
  assign down_row   = (cmd.cnt == CNT_LAST) ? row0_r : rd_row;
  assign sweep_body = cmd.sweep && (cmd.cnt > CNT_MID);
  assign flip_mask  = COLS'(1) << col_idx;

  // b3/s23 on one row with wraparound at the side edges
  always_comb begin
    int         lf;
    int         rt;
    logic [3:0] n;
    next_row = '0;
    for (int c = 0; c < COLS; c++) begin
      lf = (c == 0) ? COLS - 1 : c - 1;
      rt = (c == COLS - 1) ? 0 : c + 1;
      n = 4'(up_r[lf]) + 4'(up_r[c]) + 4'(up_r[rt]) +
          4'(mid_r[lf]) + 4'(mid_r[rt]) +
          4'(down_row[lf]) + 4'(down_row[c]) + 4'(down_row[rt]);
      next_row[c] = (n == 4'd3) || (mid_r[c] && (n == 4'd2));
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.issue) begin
      rd_en   = 1'b1;
      rd_addr = row_idx;
    end else if (cmd.sweep && (cmd.cnt <= CNT_ROWS)) begin
      rd_en   = 1'b1;
      rd_addr = (cmd.cnt == '0) ? RW'(ROWS - 1) : RW'(cmd.cnt - CNT_UP);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.look && cmd.toggle && addr_ok) begin
      wr_en   = 1'b1;
      wr_addr = row_idx;
      wr_data = rd_row ^ flip_mask;
    end else if (sweep_body) begin
      wr_en   = 1'b1;
      wr_addr = RW'(cmd.cnt - SW'(3));
      wr_data = next_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.clear) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_row;
      col_r <= in_col;
      res_r <= 1'b0;
    end else if (cmd.look) begin
      res_r <= addr_ok && (rd_row[col_idx] ^ cmd.toggle);
    end
    if (cmd.sweep) begin
      if (cmd.cnt == CNT_UP) begin
        up_r <= rd_row;
      end else if (cmd.cnt == CNT_MID) begin
        mid_r  <= rd_row;
        row0_r <= rd_row;
      end else if (sweep_body) begin
        up_r  <= mid_r;
        mid_r <= down_row;
      end
    end
    if (cmd.load_out) begin
      out_cell_r <= res_r;
    end
  end

  assign out_cell_alive = out_cell_r;

endmodule

`default_nettype wire

// ===== test/life_grid_generation_step_tb.sv =====
`timescale 1ns / 1ps

module life_grid_generation_step_tb;

  localparam int RANDOM_ITEMS = 1630;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [lgs_pkg::OP_W-1:0]    op;
    logic [lgs_pkg::FIELD_W-1:0] row;
    logic [lgs_pkg::FIELD_W-1:0] col;
    logic                        known;
    logic                        alive;
  } script_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [lgs_pkg::OP_W-1:0]    in_op = lgs_pkg::OP_READ;
  logic [lgs_pkg::FIELD_W-1:0] in_row = '0;
  logic [lgs_pkg::FIELD_W-1:0] in_col = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_cell_alive;

  // typed-in expectation that travels with the payload
  logic note_known = 1'b0;
  logic note_alive = 1'b0;

  logic [lgs_pkg::GRID_COLS-1:0] life_rows [lgs_pkg::GRID_ROWS];
  logic                          alive_expected [$];
  script_row_t                   script [$];
  int                            mismatch_count = 0;
  int                            items_sent = 0;
  int                            holdoff_requests = 0;
  int                            holdoff_served = 0;
  int                            holdoff_left = 0;
  bit                            quiet = 1'b0;
  int                            focus_row = 0;
  int                            focus_col = 0;

  life_grid_generation_step dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_row         (in_row),
    .in_col         (in_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_alive (out_cell_alive)
  );

  always #5 clk = ~clk;

  initial begin
    #6_000_000;
    $display("life_grid_generation_step_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic expv, input logic gotv);
    $display("mismatch at %0t: %s, expected %0d got %0d", $time, what, expv, gotv);
    mismatch_count++;
  endtask

  function automatic int live_neighbours(
      input int r, input int c,
      input logic [lgs_pkg::GRID_COLS-1:0] grid [lgs_pkg::GRID_ROWS]);
    int n;
    int rr;
    int cc;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) begin
          rr = (r + dr + lgs_pkg::GRID_ROWS) % lgs_pkg::GRID_ROWS;
          cc = (c + dc + lgs_pkg::GRID_COLS) % lgs_pkg::GRID_COLS;
          n += grid[rr][cc];
        end
      end
    end
    return n;
  endfunction

  // applies one command to the model grid, returns the addressed cell afterwards
  function automatic logic apply_grid_op(input logic [lgs_pkg::OP_W-1:0] op,
                                         input logic [lgs_pkg::FIELD_W-1:0] row,
                                         input logic [lgs_pkg::FIELD_W-1:0] col);
    logic [lgs_pkg::GRID_COLS-1:0] prior_rows [lgs_pkg::GRID_ROWS];
    bit                            in_grid;
    int                            n;
    in_grid = (int'(row) < lgs_pkg::GRID_ROWS) && (int'(col) < lgs_pkg::GRID_COLS);
    case (op)
      lgs_pkg::OP_TOGGLE: begin
        if (in_grid) life_rows[row][col] = ~life_rows[row][col];
      end
      lgs_pkg::OP_CLEAR: begin
        for (int r = 0; r < lgs_pkg::GRID_ROWS; r++) life_rows[r] = '0;
      end
      lgs_pkg::OP_ADVANCE: begin
        prior_rows = life_rows;
        for (int r = 0; r < lgs_pkg::GRID_ROWS; r++) begin
          for (int c = 0; c < lgs_pkg::GRID_COLS; c++) begin
            n = live_neighbours(r, c, prior_rows);
            life_rows[r][c] = (n == 3) || (prior_rows[r][c] && n == 2);
          end
        end
      end
      default: ;
    endcase
    return in_grid ? life_rows[row][col] : 1'b0;
  endfunction

  always @(posedge clk) begin : scoreboard
    logic want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (alive_expected.size() == 0) begin
          report_mismatch("result with nothing pending", 1'b0, out_cell_alive);
        end else begin
          want = alive_expected.pop_front();
          if (out_cell_alive !== want) report_mismatch("cell_alive", want, out_cell_alive);
        end
      end
      if (in_valid && in_ready) begin
        want = apply_grid_op(in_op, in_row, in_col);
        alive_expected.push_back(note_known ? note_alive : want);
      end
    end
  end

  always @(posedge clk) begin
    if (holdoff_served != holdoff_requests) begin
      holdoff_served <= holdoff_requests;
      holdoff_left <= HOLDOFF_CYCLES;
      out_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 15);
    end
  end

  task automatic send_command(input logic [lgs_pkg::OP_W-1:0] op, input int row,
                              input int col, input logic known = 1'b0,
                              input logic alive = 1'b0);
    in_valid <= 1'b1;
    in_op <= op;
    in_row <= row[lgs_pkg::FIELD_W-1:0];
    in_col <= col[lgs_pkg::FIELD_W-1:0];
    note_known <= known;
    note_alive <= alive;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (alive_expected.size() != 0) @(posedge clk);
  endtask

  function automatic logic [lgs_pkg::OP_W-1:0] pick_op();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 3) return lgs_pkg::OP_CLEAR;
    if (p < 23) return lgs_pkg::OP_ADVANCE;
    if (p < 60) return lgs_pkg::OP_TOGGLE;
    return lgs_pkg::OP_READ;
  endfunction

  function automatic int near(input int centre);
    if ($urandom_range(99) < 80) return (centre + $urandom_range(6) + 61) % 64;
    return $urandom_range(63);
  endfunction

  function automatic void add_row(input logic [lgs_pkg::OP_W-1:0] op, input int row,
                                  input int col, input logic known, input logic alive);
    script.push_back('{op, row[lgs_pkg::FIELD_W-1:0], col[lgs_pkg::FIELD_W-1:0],
                       known, alive});
  endfunction

  initial begin
    logic [lgs_pkg::OP_W-1:0] op;
    bit                       holdoff_done;
    bit                       drain_done;
    int                       base_r;
    int                       base_c;

    for (int r = 0; r < lgs_pkg::GRID_ROWS; r++) life_rows[r] = '0;

    add_row(lgs_pkg::OP_READ,    0,  0,  1'b1, 1'b0);
    add_row(lgs_pkg::OP_READ,    63, 63, 1'b1, 1'b0);
    add_row(lgs_pkg::OP_TOGGLE,  0,  0,  1'b1, 1'b1);
    add_row(lgs_pkg::OP_TOGGLE,  63, 63, 1'b1, 1'b1);
    add_row(lgs_pkg::OP_TOGGLE,  0,  63, 1'b1, 1'b1);
    // birth across the corner wrap
    add_row(lgs_pkg::OP_ADVANCE, 63, 0,  1'b0, 1'b0);
    add_row(lgs_pkg::OP_READ,    0,  0,  1'b0, 1'b0);
    add_row(lgs_pkg::OP_CLEAR,   63, 63, 1'b1, 1'b0);
    add_row(lgs_pkg::OP_READ,    63, 0,  1'b1, 1'b0);
    // blinker straddling the column edge
    add_row(lgs_pkg::OP_TOGGLE,  10, 62, 1'b1, 1'b1);
    add_row(lgs_pkg::OP_TOGGLE,  10, 63, 1'b1, 1'b1);
    add_row(lgs_pkg::OP_TOGGLE,  10, 0,  1'b1, 1'b1);
    add_row(lgs_pkg::OP_ADVANCE, 9,  63, 1'b0, 1'b0);
    add_row(lgs_pkg::OP_ADVANCE, 10, 62, 1'b0, 1'b0);
    add_row(lgs_pkg::OP_READ,    10, 0,  1'b0, 1'b0);
    add_row(lgs_pkg::OP_TOGGLE,  42, 21, 1'b1, 1'b1);
    add_row(lgs_pkg::OP_TOGGLE,  42, 21, 1'b1, 1'b0);
    add_row(lgs_pkg::OP_ADVANCE, 0,  0,  1'b0, 1'b0);
    add_row(lgs_pkg::OP_CLEAR,   0,  0,  1'b1, 1'b0);
    add_row(lgs_pkg::OP_ADVANCE, 33, 33, 1'b1, 1'b0);
    add_row(lgs_pkg::OP_READ,    21, 42, 1'b1, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      send_command(script[i].op, script[i].row, script[i].col, script[i].known,
                   script[i].alive);
    end

    holdoff_done = 1'b0;
    drain_done = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      quiet = (items_sent >= 900 && items_sent < 1200);
      if (!holdoff_done && items_sent >= 300) begin
        holdoff_requests++;
        holdoff_done = 1'b1;
      end
      if (!drain_done && items_sent >= 600) begin
        wait_drained();
        drain_done = 1'b1;
      end
      if (items_sent % 40 == 0) begin
        focus_row = $urandom_range(63);
        focus_col = $urandom_range(63);
      end
      if ($urandom_range(99) < 8) begin
        // glider dropped near the focus, then a few generations
        base_r = near(focus_row);
        base_c = near(focus_col);
        send_command(lgs_pkg::OP_TOGGLE, base_r,            (base_c + 1) % 64);
        send_command(lgs_pkg::OP_TOGGLE, (base_r + 1) % 64, (base_c + 2) % 64);
        send_command(lgs_pkg::OP_TOGGLE, (base_r + 2) % 64, base_c);
        send_command(lgs_pkg::OP_TOGGLE, (base_r + 2) % 64, (base_c + 1) % 64);
        send_command(lgs_pkg::OP_TOGGLE, (base_r + 2) % 64, (base_c + 2) % 64);
        repeat ($urandom_range(4, 1)) begin
          send_command(lgs_pkg::OP_ADVANCE, near(base_r), near(base_c));
        end
      end else begin
        op = pick_op();
        send_command(op, near(focus_row), near(focus_col));
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && alive_expected.size() == 0) begin
      $display("life_grid_generation_step_tb passed");
    end else begin
      $display("life_grid_generation_step_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lgs_pkg.sv
rtl/core/lgs_ctrl.sv
rtl/core/lgs_datapath.sv
rtl/core/life_grid_generation_step.sv
test/life_grid_generation_step_tb.sv
